### sv/sapd_pkg.sv
// types, constants and helper functions shared by the allpass delay stage
// no dependencies
package sapd_pkg;

  localparam int STORE_DEPTH    = 4096;
  localparam int SAMPLES_PER_MS = 48;
  localparam int ADDR_W         = $clog2(STORE_DEPTH);
  localparam int FILL_W         = $clog2(STORE_DEPTH + 1);
  localparam int DELAY_W        = 7;
  localparam int GAIN_W         = 15;
  localparam int CFG_DATA_W     = 15;
  localparam int CFG_IDX_W      = 2;
  localparam int SAMPLES_W      = $clog2((2 ** DELAY_W - 1) * SAMPLES_PER_MS + 1);
  localparam int Q_DEPTH        = 4;
  localparam int QPTR_W         = $clog2(Q_DEPTH);
  localparam int QCNT_W         = $clog2(Q_DEPTH + 1);
  localparam int PROD_W         = 18;
  localparam int SUM_W          = 19;

  localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(19660);
  localparam logic [GAIN_W-1:0] G2_RESET   =
    GAIN_W'(32767 - (19660 * 19660) / 32768);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN  = 2'd0,
    REG_DELAY = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    logic signed [15:0] sample_in;
    logic               block_end_in;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] sample_out;
    logic               block_end_out;
  } out_item_t;

  typedef struct packed {
    logic                  we;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] d;
    logic               block_end;
    logic [ADDR_W-1:0]  wa;
  } q_entry_t;

  typedef struct packed {
    logic               we;
    logic [ADDR_W-1:0]  addr;
    logic signed [15:0] data;
  } store_wr_t;

  function automatic logic signed [15:0] sat16(input logic signed [SUM_W-1:0] v);
    logic signed [15:0] r;
    if (v[SUM_W-1:15] != {(SUM_W - 15){v[15]}}) begin
      r = v[SUM_W-1] ? 16'sh8000 : 16'sh7fff;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  function automatic logic signed [PROD_W-1:0] q15_term(input logic signed [32:0] p);
    return p[32:15];
  endfunction

endpackage

### sv/schroeder_allpass_delay.sv
// schroeder allpass stage: front end with delay store, queue, arithmetic back end
// depends on sapd_pkg, sapd_front, sapd_queue, sapd_back
// path: store read and input registers, queue entry, product registers, output register
// throughput: one item per cycle unless the output stalls; store has one read and one write port
// reset: asynchronous, clears pointers, fill count and valid flags; gain returns to 0.6, delay to 0
// the store reads as zero at every entry not yet written, tracked by a fill count, no clearing pass
module schroeder_allpass_delay (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  sapd_pkg::in_item_t                 in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output sapd_pkg::out_item_t                out_data_o,
  input  logic                               cfg_we_i,
  input  logic [sapd_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [sapd_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  sapd_pkg::cfg_wr_t               cfg;
  sapd_pkg::store_wr_t             wr;
  sapd_pkg::q_entry_t              push_data, pop_data;
  logic                            push, pop, pop_valid;
  logic [sapd_pkg::QCNT_W-1:0]     q_count;

  assign cfg.we   = cfg_we_i;
  assign cfg.idx  = cfg_idx_i;
  assign cfg.data = cfg_data_i;

  sapd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .cfg_i       (cfg),
    .wr_i        (wr),
    .q_count_i   (q_count),
    .push_o      (push),
    .push_data_o (push_data)
  );

  sapd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_valid_o (pop_valid),
    .pop_data_o  (pop_data),
    .count_o     (q_count)
  );

  sapd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .pop_valid_i (pop_valid),
    .pop_o       (pop),
    .pop_data_i  (pop_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .wr_o        (wr)
  );

endmodule

### sv/sapd_front.sv
// front end: input handshake, delay pointers, delay store and its fill count
// depends on sapd_pkg
module sapd_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  sapd_pkg::in_item_t             in_data_i,
  input  sapd_pkg::cfg_wr_t              cfg_i,
  input  sapd_pkg::store_wr_t            wr_i,
  input  logic [sapd_pkg::QCNT_W-1:0]    q_count_i,
  output logic                           push_o,
  output sapd_pkg::q_entry_t             push_data_o
);

  logic signed [15:0]                mem [sapd_pkg::STORE_DEPTH];
  logic signed [15:0]                rdata_q;
  logic [sapd_pkg::ADDR_W-1:0]       wp_q, wp_d;
  logic [sapd_pkg::ADDR_W-1:0]       rp_q, rp_d;
  logic [sapd_pkg::FILL_W-1:0]       fill_q, fill_d;
  logic                              rd_ok_q, rd_ok_d;
  logic                              s1_v_q;
  logic signed [15:0]                s1_x_q;
  logic                              s1_be_q;
  logic [sapd_pkg::ADDR_W-1:0]       s1_wa_q;
  logic                              accept;
  logic                              dly_wr;
  logic [sapd_pkg::QCNT_W:0]         busy;
  logic [sapd_pkg::SAMPLES_W-1:0]    samples;
  logic [sapd_pkg::FILL_W-1:0]       clamped;
  logic [sapd_pkg::FILL_W:0]         back_sum;
  logic [sapd_pkg::ADDR_W-1:0]       rp_cfg;

  function automatic logic [sapd_pkg::ADDR_W-1:0] wrap_inc(
    input logic [sapd_pkg::ADDR_W-1:0] p
  );
    logic [sapd_pkg::ADDR_W-1:0] r;
    if (p == sapd_pkg::ADDR_W'(sapd_pkg::STORE_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

  assign busy       = (sapd_pkg::QCNT_W + 1)'(q_count_i) + (sapd_pkg::QCNT_W + 1)'(s1_v_q);
  assign in_ready_o = busy < (sapd_pkg::QCNT_W + 1)'(sapd_pkg::Q_DEPTH);
  assign accept     = in_valid_i & in_ready_o;
  assign dly_wr     = cfg_i.we && (cfg_i.idx == sapd_pkg::REG_DELAY);

  // read pointer trails the write pointer by the delay in samples
  always_comb begin
    samples = sapd_pkg::SAMPLES_W'(cfg_i.data[sapd_pkg::DELAY_W-1:0])
            * sapd_pkg::SAMPLES_W'(sapd_pkg::SAMPLES_PER_MS);
    if (int'(samples) > sapd_pkg::STORE_DEPTH) begin
      clamped = sapd_pkg::FILL_W'(sapd_pkg::STORE_DEPTH);
    end else begin
      clamped = sapd_pkg::FILL_W'(samples);
    end
    back_sum = (sapd_pkg::FILL_W + 1)'(wp_q)
             + (sapd_pkg::FILL_W + 1)'(sapd_pkg::STORE_DEPTH)
             - (sapd_pkg::FILL_W + 1)'(clamped);
    if (back_sum >= (sapd_pkg::FILL_W + 1)'(sapd_pkg::STORE_DEPTH)) begin
      back_sum = back_sum - (sapd_pkg::FILL_W + 1)'(sapd_pkg::STORE_DEPTH);
    end
    rp_cfg = back_sum[sapd_pkg::ADDR_W-1:0];
  end

  always_comb begin
    wp_d    = wp_q;
    rp_d    = rp_q;
    fill_d  = fill_q;
    rd_ok_d = rd_ok_q;
    priority if (dly_wr) begin
      rp_d = rp_cfg;
    end else if (accept) begin
      wp_d    = wrap_inc(wp_q);
      rp_d    = wrap_inc(rp_q);
      rd_ok_d = sapd_pkg::FILL_W'(rp_q) < fill_q;
    end else begin
      rp_d = rp_q;
    end
    if (wr_i.we && (fill_q != sapd_pkg::FILL_W'(sapd_pkg::STORE_DEPTH))) begin
      fill_d = fill_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q    <= '0;
      rp_q    <= '0;
      fill_q  <= '0;
      rd_ok_q <= 1'b0;
      s1_v_q  <= 1'b0;
    end else begin
      wp_q    <= wp_d;
      rp_q    <= rp_d;
      fill_q  <= fill_d;
      rd_ok_q <= rd_ok_d;
      s1_v_q  <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    if (accept) begin
      rdata_q <= mem[rp_q];
      s1_x_q  <= in_data_i.sample_in;
      s1_be_q <= in_data_i.block_end_in;
      s1_wa_q <= wp_q;
    end
  end

  assign push_o            = s1_v_q;
  assign push_data_o.x     = s1_x_q;
  assign push_data_o.d     = rd_ok_q ? rdata_q : 16'sd0;
  assign push_data_o.block_end = s1_be_q;
  assign push_data_o.wa    = s1_wa_q;

endmodule

### sv/sapd_queue.sv
// short queue between the front end and the arithmetic back end
// depends on sapd_pkg
module sapd_queue (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push_i,
  input  sapd_pkg::q_entry_t             push_data_i,
  input  logic                           pop_i,
  output logic                           pop_valid_o,
  output sapd_pkg::q_entry_t             pop_data_o,
  output logic [sapd_pkg::QCNT_W-1:0]    count_o
);

  sapd_pkg::q_entry_t                entries [sapd_pkg::Q_DEPTH];
  logic [sapd_pkg::QPTR_W-1:0]       wr_q, rd_q;
  logic [sapd_pkg::QCNT_W-1:0]       cnt_q, cnt_d;

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_q <= (wr_q == sapd_pkg::QPTR_W'(sapd_pkg::Q_DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == sapd_pkg::QPTR_W'(sapd_pkg::Q_DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries[wr_q] <= push_data_i;
    end
  end

  assign pop_valid_o = cnt_q != '0;
  assign pop_data_o  = entries[rd_q];
  assign count_o     = cnt_q;

endmodule

### sv/sapd_back.sv
// back end: gain registers, q15 products, saturating sums, store write-back
// and output register; depends on sapd_pkg
module sapd_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  sapd_pkg::cfg_wr_t    cfg_i,
  input  logic                 pop_valid_i,
  output logic                 pop_o,
  input  sapd_pkg::q_entry_t   pop_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output sapd_pkg::out_item_t  out_data_o,
  output sapd_pkg::store_wr_t  wr_o
);

  logic [sapd_pkg::GAIN_W-1:0]       gain_q, g2_q, g2_d;
  logic [2*sapd_pkg::GAIN_W-1:0]     gg;
  logic signed [16:0]                gs, g2s, neg_g;
  logic signed [32:0]                p_xg, p_dg2, p_dg;
  logic                              b1_v_q, out_v_q;
  logic signed [sapd_pkg::PROD_W-1:0] b1_xg_q, b1_dg2_q, b1_dg_q;
  logic signed [15:0]                b1_x_q;
  logic                              b1_be_q;
  logic [sapd_pkg::ADDR_W-1:0]       b1_wa_q;
  logic signed [15:0]                y, w;
  logic                              out_adv, b1_move;
  sapd_pkg::out_item_t               out_q;

  assign gg    = gain_q * gain_q;
  assign g2_d  = sapd_pkg::GAIN_W'(15'h7fff) - gg[2*sapd_pkg::GAIN_W-1:sapd_pkg::GAIN_W];
  assign gs    = $signed({2'b00, gain_q});
  assign g2s   = $signed({2'b00, g2_q});
  assign neg_g = -gs;

  assign p_xg  = 33'(pop_data_i.x) * 33'(neg_g);
  assign p_dg2 = 33'(pop_data_i.d) * 33'(g2s);
  assign p_dg  = 33'(pop_data_i.d) * 33'(gs);

  assign y = sapd_pkg::sat16(sapd_pkg::SUM_W'(b1_xg_q) + sapd_pkg::SUM_W'(b1_dg2_q));
  assign w = sapd_pkg::sat16(sapd_pkg::SUM_W'(b1_dg_q) + sapd_pkg::SUM_W'(b1_x_q));

  assign out_adv = !out_v_q || out_ready_i;
  assign b1_move = b1_v_q && out_adv;
  assign pop_o   = pop_valid_i && (!b1_v_q || b1_move);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q  <= sapd_pkg::GAIN_RESET;
      g2_q    <= sapd_pkg::G2_RESET;
      b1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (cfg_i.we && (cfg_i.idx == sapd_pkg::REG_GAIN)) begin
        gain_q <= cfg_i.data[sapd_pkg::GAIN_W-1:0];
      end
      g2_q <= g2_d;
      if (pop_o) begin
        b1_v_q <= 1'b1;
      end else if (b1_move) begin
        b1_v_q <= 1'b0;
      end
      if (out_adv) begin
        out_v_q <= b1_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      b1_xg_q  <= sapd_pkg::q15_term(p_xg);
      b1_dg2_q <= sapd_pkg::q15_term(p_dg2);
      b1_dg_q  <= sapd_pkg::q15_term(p_dg);
      b1_x_q   <= pop_data_i.x;
      b1_be_q  <= pop_data_i.block_end;
      b1_wa_q  <= pop_data_i.wa;
    end
    if (b1_move) begin
      out_q.sample_out    <= y;
      out_q.block_end_out <= b1_be_q;
    end
  end

  assign wr_o.we      = b1_move;
  assign wr_o.addr    = b1_wa_q;
  assign wr_o.data    = w;
  assign out_valid_o  = out_v_q;
  assign out_data_o   = out_q;

endmodule

### sv/sapd_check.sv
// port-level checks for the allpass delay stage, bound to the top level
// depends on sapd_pkg and schroeder_allpass_delay
module sapd_check (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_ready_o,
  input logic                               out_valid_o,
  input logic                               out_ready_i,
  input sapd_pkg::out_item_t                out_data_o,
  input logic                               cfg_we_i
);

  logic [3:0] pending_q;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else if (in_acc && !out_acc) begin
      pending_q <= pending_q + 1'b1;
    end else if (!in_acc && out_acc) begin
      pending_q <= pending_q - 1'b1;
    end
  end

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // no result without an item in flight
  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pending_q != 4'd0)
    else $error("result without pending item");

  // in-flight items stay within queue plus pipeline room
  a_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q <= 4'(sapd_pkg::Q_DEPTH + 2))
    else $error("too many items in flight");

  // an empty block takes items
  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q == 4'd0 |-> in_ready_o)
    else $error("empty block not ready");

  // register writes only while nothing is in flight
  a_cfg_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |-> pending_q == 4'd0)
    else $error("register write with items in flight");

endmodule

bind schroeder_allpass_delay sapd_check u_sapd_check (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o),
  .cfg_we_i    (cfg_we_i)
);
